/* sv/dlpd_pkg.sv */
// Shared types and constants for the locomotive packet decoder.
package dlpd_pkg;

  // Command codes reported with every result beat.
  typedef enum logic [4:0] {
    CMD_IGNORE       = 5'd0,
    CMD_SPEED        = 5'd1,
    CMD_ESTOP        = 5'd2,
    CMD_OTHER_MOVING = 5'd3,
    CMD_OTHER_STOP   = 5'd4,
    CMD_CV_ACCESS    = 5'd5,
    CMD_RESET        = 5'd6,
    CMD_F0_F4        = 5'd7,
    CMD_F5_F8        = 5'd8,
    CMD_F9_F12       = 5'd9,
    CMD_F13_F20      = 5'd10,
    CMD_F21_F28      = 5'd11,
    CMD_F29_F36      = 5'd12,
    CMD_F37_F44      = 5'd13,
    CMD_F45_F52      = 5'd14,
    CMD_F53_F60      = 5'd15,
    CMD_F61_F68      = 5'd16,
    CMD_BIN_BCAST    = 5'd17,
    CMD_BIN_APP      = 5'd18
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ADDR_FIRST = 1'b0,
    CFG_ADDR_LAST  = 1'b1
  } cfg_reg_e;

  // Instruction patterns.
  localparam logic [7:0] INSTR_SPEED128    = 8'h3F;
  localparam logic [7:0] INSTR_RESET       = 8'h00;
  localparam logic [7:0] INSTR_BIN_SHORT   = 8'hDD;
  localparam logic [7:0] INSTR_BIN_LONG    = 8'hC0;
  localparam logic [4:0] INSTR_FEXP_PREFIX = 5'b11011;
  localparam logic [2:0] FEXP_F13_F20      = 3'd6;
  localparam logic [2:0] FEXP_F21_F28      = 3'd7;
  localparam logic [2:0] FEXP_LAST_BYTE    = 3'd4;

  // Binary state numbers that map on to F29 upwards.
  localparam logic [14:0] BIN_FIRST_FUNC = 15'd29;
  localparam logic [14:0] BIN_LAST_LOW   = 15'd28;
  localparam logic [14:0] BIN_LAST_FUNC  = 15'd68;

  localparam logic [15:0] ADDR_RESET = 16'hFFFF;

  // One packet as it arrives.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } pkt_t;

  // Stored locomotive state.
  typedef struct packed {
    logic [6:0]  speed;
    logic        fwd;
    logic        estop;
    logic [4:0]  f0_f4;
    logic [3:0]  f5_f8;
    logic [3:0]  f9_f12;
    logic [7:0]  f13_f20;
    logic [7:0]  f21_f28;
    logic [39:0] f29_f68;
    logic [14:0] bin_num;
    logic        bin_val;
  } loco_state_t;

  localparam loco_state_t STATE_RESET = '{
    speed:   7'd0,
    fwd:     1'b1,
    estop:   1'b0,
    f0_f4:   5'd0,
    f5_f8:   4'd0,
    f9_f12:  4'd0,
    f13_f20: 8'd0,
    f21_f28: 8'd0,
    f29_f68: 40'd0,
    bin_num: 15'd0,
    bin_val: 1'b0
  };

  // Per-packet decode outcome.
  typedef struct packed {
    cmd_e        code;
    logic [13:0] addr;
    logic        is_long;
  } dec_res_t;

endpackage

/* sv/dlpd_in_if.sv */
// Packet input channel: valid/ready handshake carrying five packet bytes.
interface dlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte0;
  logic [7:0] packet_byte1;
  logic [7:0] packet_byte2;
  logic [7:0] packet_byte3;
  logic [7:0] packet_byte4;

  modport source (
    output valid, packet_byte0, packet_byte1, packet_byte2, packet_byte3, packet_byte4,
    input  ready
  );
  modport sink (
    input  valid, packet_byte0, packet_byte1, packet_byte2, packet_byte3, packet_byte4,
    output ready
  );
endinterface

/* sv/dlpd_out_if.sv */
// Result channel: valid/ready handshake carrying the command code and loco state.
interface dlpd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd_code;
  logic [13:0] loco_address;
  logic        is_long_address;
  logic [6:0]  speed_step;
  logic        moving_forward;
  logic [4:0]  funcs_f0_f4;
  logic [7:0]  funcs_f5_f12;
  logic [7:0]  funcs_f13_f20;
  logic [7:0]  funcs_f21_f28;
  logic [39:0] funcs_f29_f68;
  logic [14:0] binary_state_num;
  logic        binary_state_on;

  modport source (
    output valid, cmd_code, loco_address, is_long_address, speed_step, moving_forward,
           funcs_f0_f4, funcs_f5_f12, funcs_f13_f20, funcs_f21_f28, funcs_f29_f68,
           binary_state_num, binary_state_on,
    input  ready
  );
  modport sink (
    input  valid, cmd_code, loco_address, is_long_address, speed_step, moving_forward,
           funcs_f0_f4, funcs_f5_f12, funcs_f13_f20, funcs_f21_f28, funcs_f29_f68,
           binary_state_num, binary_state_on,
    output ready
  );
endinterface

/* sv/dlpd_decode.sv */
// Combinational instruction decode and next-state computation for one packet.
module dlpd_decode (
  input  dlpd_pkg::pkt_t        pkt_i,
  input  logic [15:0]           addr_first_i,
  input  logic [15:0]           addr_last_i,
  input  dlpd_pkg::loco_state_t state_i,
  output dlpd_pkg::loco_state_t state_o,
  output dlpd_pkg::dec_res_t    res_o
);
  import dlpd_pkg::*;

  logic        is_long;
  logic [13:0] addr;
  logic [7:0]  instr;
  logic [7:0]  d1;
  logic [7:0]  d2;
  logic        mine;

  logic        is_sp28;
  logic        is_sp128;
  logic [4:0]  raw28;
  logic [6:0]  raw128;
  logic [6:0]  sp_step;
  logic        sp_fwd;
  logic        sp_estop;

  logic [2:0]  fgrp;
  logic [5:0]  fbyte_lsb;
  logic [14:0] bin_num;
  logic        bin_val;
  logic [14:0] bin_off;
  logic [5:0]  bin_bit;

  cmd_e        code;
  loco_state_t nxt;

  // Address extraction and range check.
  always_comb begin
    is_long = pkt_i.b0[7];
    if (is_long) begin
      addr  = {pkt_i.b0[5:0], pkt_i.b1};
      instr = pkt_i.b2;
      d1    = pkt_i.b3;
      d2    = pkt_i.b4;
    end else begin
      addr  = {7'd0, pkt_i.b0[6:0]};
      instr = pkt_i.b1;
      d1    = pkt_i.b2;
      d2    = pkt_i.b3;
    end
    mine = ({2'b00, addr} >= addr_first_i) && ({2'b00, addr} <= addr_last_i);
  end

  // Speed field decode for both the 28-step and the 128-step forms.
  always_comb begin
    is_sp28  = (instr[7:6] == 2'b01);
    is_sp128 = (instr == INSTR_SPEED128);
    raw28    = {instr[3:0], instr[4]};
    raw128   = d1[6:0];
    if (is_sp28) begin
      sp_fwd = instr[5];
      if (raw28 <= 5'd3) begin
        sp_estop = raw28[1];
        sp_step  = 7'd0;
      end else begin
        sp_estop = 1'b0;
        sp_step  = {2'b00, raw28 - 5'd3};
      end
    end else begin
      sp_fwd = d1[7];
      if (raw128 <= 7'd1) begin
        sp_estop = raw128[0];
        sp_step  = 7'd0;
      end else begin
        sp_estop = 1'b0;
        sp_step  = raw128 - 7'd1;
      end
    end
  end

  // Function-group and binary state operands.
  always_comb begin
    fgrp      = instr[2:0];
    fbyte_lsb = {fgrp, 3'b000};
    bin_val   = d1[7];
    bin_num   = (instr == INSTR_BIN_LONG) ? {d2, d1[6:0]} : {8'd0, d1[6:0]};
    bin_off   = bin_num - BIN_FIRST_FUNC;
    bin_bit   = bin_off[5:0];
  end

  // Instruction decode and state update.
  always_comb begin
    nxt  = state_i;
    code = CMD_IGNORE;
    if (is_sp28 || is_sp128) begin
      if (!mine) begin
        code = (sp_step != 7'd0) ? CMD_OTHER_MOVING : CMD_OTHER_STOP;
      end else if (state_i.estop == sp_estop && state_i.speed == sp_step &&
                   state_i.fwd == sp_fwd) begin
        code = CMD_IGNORE;
      end else if (sp_estop) begin
        nxt.speed = 7'd0;
        nxt.estop = 1'b1;
        code      = CMD_ESTOP;
      end else begin
        nxt.speed = sp_step;
        nxt.estop = 1'b0;
        nxt.fwd   = sp_fwd;
        code      = CMD_SPEED;
      end
    end else if (!mine) begin
      code = CMD_IGNORE;
    end else if (instr[7:4] == 4'hE) begin
      code = CMD_CV_ACCESS;
    end else if (instr == INSTR_RESET) begin
      nxt       = STATE_RESET;
      nxt.estop = state_i.estop;
      code      = CMD_RESET;
    end else if (instr[7:5] == 3'b100) begin
      if (state_i.f0_f4 != instr[4:0]) begin
        nxt.f0_f4 = instr[4:0];
        code      = CMD_F0_F4;
      end
    end else if (instr[7:5] == 3'b101) begin
      if (instr[4]) begin
        if (state_i.f5_f8 != instr[3:0]) begin
          nxt.f5_f8 = instr[3:0];
          code      = CMD_F5_F8;
        end
      end else if (state_i.f9_f12 != instr[3:0]) begin
        nxt.f9_f12 = instr[3:0];
        code       = CMD_F9_F12;
      end
    end else if (instr[7:3] == INSTR_FEXP_PREFIX && fgrp != 3'd5) begin
      // Feature expansion: F13-F20, F21-F28 or one byte of F29-F68.
      if (fgrp == FEXP_F13_F20) begin
        if (state_i.f13_f20 != d1) begin
          nxt.f13_f20 = d1;
          code        = CMD_F13_F20;
        end
      end else if (fgrp == FEXP_F21_F28) begin
        if (state_i.f21_f28 != d1) begin
          nxt.f21_f28 = d1;
          code        = CMD_F21_F28;
        end
      end else if (fgrp <= FEXP_LAST_BYTE) begin
        if (state_i.f29_f68[fbyte_lsb +: 8] != d1) begin
          nxt.f29_f68[fbyte_lsb +: 8] = d1;
          code = cmd_e'(5'(CMD_F29_F36) + {2'b00, fgrp});
        end
      end
    end else if (instr == INSTR_BIN_SHORT || instr == INSTR_BIN_LONG) begin
      // Binary state: the short form carries seven bits of number, the long fifteen.
      if (!(state_i.bin_num == bin_num && state_i.bin_val == bin_val)) begin
        nxt.bin_num = bin_num;
        nxt.bin_val = bin_val;
        if (bin_num == 15'd0) begin
          nxt.f29_f68 = {40{bin_val}};
          code        = CMD_BIN_BCAST;
        end else if (bin_num <= BIN_LAST_LOW) begin
          code = CMD_IGNORE;
        end else if (bin_num <= BIN_LAST_FUNC) begin
          nxt.f29_f68[bin_bit] = bin_val;
          code = cmd_e'(5'(CMD_F29_F36) + {2'b00, bin_bit[5:3]});
        end else begin
          code = CMD_BIN_APP;
        end
      end
    end
  end

  assign state_o       = nxt;
  assign res_o.code    = code;
  assign res_o.addr    = addr;
  assign res_o.is_long = is_long;

endmodule

/* sv/dcc_loco_packet_decoder_top.sv */
// Top level of the locomotive packet decoder: registers, handshake and state.
//
// Decodes one model railway command packet per clock cycle while res_o is not
// stalled: a packet beat accepted on pkt_i lands in an input register, is decoded
// from there, and its result beat is loaded into the result register and presented
// on res_o. The throughput is set by the update of the locomotive state register,
// which each packet reads and writes.
// The state fields on res_o show the state after that packet. Address range
// registers (index 0 first, index 1 last, both reset to 0xFFFF) must be written by
// the user through cfg_we_i only while no packet is in flight; the block itself
// does not enforce this.
module dcc_loco_packet_decoder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  dlpd_in_if.sink          pkt_i,
  dlpd_out_if.source       res_o
);
  import dlpd_pkg::*;

  logic [15:0] addr_first_q;
  logic [15:0] addr_last_q;

  logic        s1_valid_q;
  pkt_t        s1_pkt_q;
  logic        out_valid_q;
  dec_res_t    out_res_q;
  loco_state_t state_q;

  loco_state_t state_d;
  dec_res_t    dec_res;
  logic        in_beat;
  logic        adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_first_q <= ADDR_RESET;
      addr_last_q  <= ADDR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ADDR_FIRST: addr_first_q <= cfg_data_i;
        CFG_ADDR_LAST:  addr_last_q  <= cfg_data_i;
        default:        addr_first_q <= addr_first_q;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign adv         = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pkt_i.ready = !s1_valid_q || adv;
  assign in_beat     = pkt_i.valid && pkt_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_beat) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_pkt_q <= '{b0: pkt_i.packet_byte0, b1: pkt_i.packet_byte1,
                    b2: pkt_i.packet_byte2, b3: pkt_i.packet_byte3,
                    b4: pkt_i.packet_byte4};
    end
  end

  dlpd_decode u_decode (
    .pkt_i        (s1_pkt_q),
    .addr_first_i (addr_first_q),
    .addr_last_i  (addr_last_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .res_o        (dec_res)
  );

  // Loco state and result register load together, so the state also serves as
  // the state part of the waiting result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= dec_res;
    end
  end

  // Result channel.
  assign res_o.valid            = out_valid_q;
  assign res_o.cmd_code         = out_res_q.code;
  assign res_o.loco_address     = out_res_q.addr;
  assign res_o.is_long_address  = out_res_q.is_long;
  assign res_o.speed_step       = state_q.speed;
  assign res_o.moving_forward   = state_q.fwd;
  assign res_o.funcs_f0_f4      = state_q.f0_f4;
  assign res_o.funcs_f5_f12     = {state_q.f9_f12, state_q.f5_f8};
  assign res_o.funcs_f13_f20    = state_q.f13_f20;
  assign res_o.funcs_f21_f28    = state_q.f21_f28;
  assign res_o.funcs_f29_f68    = state_q.f29_f68;
  assign res_o.binary_state_num = state_q.bin_num;
  assign res_o.binary_state_on  = state_q.bin_val;

`ifndef ASSERT_OFF
  // A stalled result beat must not see the loco state move underneath it.
  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> $stable(state_q))
    else $error("loco state changed while a result beat was stalled");

  // A held packet stays in the input register until it is decoded.
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q)
    else $error("packet dropped from the input register");

  // An emergency stop result always shows a stopped loco with the stop flag set.
  a_estop_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.code == CMD_ESTOP) |-> (state_q.speed == 7'd0 && state_q.estop))
    else $error("emergency stop reported with nonzero speed");
`endif

endmodule
